>>> rtl/uvs_pkg.sv
// ----------------------------------------------------------------------------
// uvs_pkg
// Shared widths and error codes for the UV seam vertex splitter.
// ----------------------------------------------------------------------------
package uvs_pkg;

    localparam int POS_W = 12;   // position index width
    localparam int TEX_W = 16;   // texcoord index width
    localparam int CNT_W = 13;   // base count / free pointer width
    localparam int ERR_W = 2;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK    = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_RANGE = 2'd2
    } t_err;

endpackage

>>> rtl/uvs_slot_mem.sv
// ----------------------------------------------------------------------------
// uvs_slot_mem
// Slot table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module uvs_slot_mem #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 42,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/uv_seam_vertex_split.sv
// ----------------------------------------------------------------------------
// uv_seam_vertex_split
// Assigns output vertex slots to face corners, cloning vertices on UV seams.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive i_position_index / i_texcoord_index and raise start;
//   the item is taken at a clock edge where start is high and busy is low.
//   One result per item appears on o_slot_index / o_new_clone / o_error_code
//   for exactly one cycle, flagged by o_valid. The receiver cannot stall.
//   Config: i_cfg_we with i_cfg_wdata loads base_vertex_count and reloads the
//   free clone pointer. Write it only while busy is low.
// Flow (one item at a time, all state in one slot memory):
//   out-of-range index ........ reported straight from idle, no memory read
//   first use or direct hit ... one read of the base slot, checked in S_VCHK
//   hit on k-th clone ......... base read, then one memory read per chain link
//   new clone / table full .... any walk, then S_ALLOC, S_FRESH, S_LINK / S_ALLOC
//   The single read port of the slot memory is walked one link per cycle.
// Reset: a clearing pass zeroes the used/clone flags of every slot; busy
//   stays high during the pass. Config writes are taken during the pass.
// ----------------------------------------------------------------------------
module uv_seam_vertex_split #(
    parameter int MAX_SLOTS = 4096
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [uvs_pkg::CNT_W-1:0]    i_cfg_wdata,
    input  logic                         start,
    output logic                         busy,
    input  logic [uvs_pkg::POS_W-1:0]    i_position_index,
    input  logic [uvs_pkg::TEX_W-1:0]    i_texcoord_index,
    output logic                         o_valid,
    output logic [uvs_pkg::POS_W-1:0]    o_slot_index,
    output logic                         o_new_clone,
    output logic [uvs_pkg::ERR_W-1:0]    o_error_code
);

    import uvs_pkg::*;

    localparam int SW = $clog2(MAX_SLOTS);

    // one slot entry: head is used when the slot is a base vertex,
    // nxt when it is a clone; present is shared by both roles
    typedef struct packed {
        logic             used;
        logic             present;
        logic [TEX_W-1:0] tex;
        logic [SW-1:0]    head;
        logic [SW-1:0]    nxt;
    } t_entry;

    localparam int EW = $bits(t_entry);

    typedef enum logic [2:0] {
        S_CLR, S_IDLE, S_VCHK, S_WALK, S_ALLOC, S_FRESH, S_LINK
    } t_state;

    t_state           r_state;
    logic [SW-1:0]    r_clr;
    logic [SW-1:0]    r_pos;     // base vertex slot of the item
    logic [TEX_W-1:0] r_tex;
    t_entry           r_ve;      // entry of the base vertex
    t_entry           r_fe;      // freshly written clone entry
    logic [SW-1:0]    r_s;       // chain slot under test
    logic [SW:0]      r_steps;
    logic [CNT_W-1:0] r_base;
    logic [CNT_W-1:0] r_free;
    logic             r_valid;
    logic [POS_W-1:0] r_slot;
    logic             r_clone;
    t_err             r_err;

    logic             m_we;
    logic [SW-1:0]    m_waddr;
    t_entry           m_wdata;
    logic             m_re;
    logic [SW-1:0]    m_raddr;
    logic [EW-1:0]    m_rdata;
    t_entry           rd;

    logic             in_range;
    logic             free_ok;
    logic             walk_more;
    logic [SW-1:0]    free_addr;
    t_entry           fresh_new;
    t_entry           link_base;

    assign rd        = t_entry'(m_rdata);
    assign in_range  = ({1'b0, i_position_index} < r_base)
                     && (int'(i_position_index) < MAX_SLOTS);
    assign free_ok   = int'(r_free) < MAX_SLOTS;
    assign free_addr = SW'(r_free);
    // another link exists and the step budget is not spent
    assign walk_more = rd.present && ((int'(r_steps) + 1) < MAX_SLOTS);

    // new clone takes the old chain as its tail and keeps its own head field
    always_comb begin
        fresh_new         = rd;
        fresh_new.used    = 1'b1;
        fresh_new.present = r_ve.present;
        fresh_new.tex     = r_tex;
        fresh_new.nxt     = r_ve.head;
    end

    // if the clone landed on the base slot itself, link on top of it
    always_comb begin
        link_base         = (free_addr == r_pos) ? r_fe : r_ve;
        link_base.head    = free_addr;
        link_base.present = 1'b1;
    end

    // memory port control
    always_comb begin
        m_we    = 1'b0;
        m_waddr = r_pos;
        m_wdata = rd;
        m_re    = 1'b0;
        m_raddr = SW'(i_position_index);
        case (r_state)
            S_CLR: begin
                m_we    = 1'b1;
                m_waddr = r_clr;
                m_wdata = '0;
            end
            S_IDLE: begin
                m_re = start && in_range;
            end
            S_VCHK: begin
                if (!rd.used) begin
                    m_we         = 1'b1;
                    m_wdata.used = 1'b1;
                    m_wdata.tex  = r_tex;
                end else if (rd.tex != r_tex && rd.present) begin
                    m_re    = 1'b1;
                    m_raddr = rd.head;
                end
            end
            S_WALK: begin
                m_re    = (rd.tex != r_tex) && walk_more;
                m_raddr = rd.nxt;
            end
            S_ALLOC: begin
                m_re    = free_ok;
                m_raddr = free_addr;
            end
            S_FRESH: begin
                m_we    = 1'b1;
                m_waddr = free_addr;
                m_wdata = fresh_new;
            end
            S_LINK: begin
                m_we    = 1'b1;
                m_waddr = r_pos;
                m_wdata = link_base;
            end
            default: begin
                m_we = 1'b0;
            end
        endcase
    end

    uvs_slot_mem #(
        .DEPTH (MAX_SLOTS),
        .WIDTH (EW),
        .AW    (SW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (m_waddr),
        .i_wdata (EW'(m_wdata)),
        .i_re    (m_re),
        .i_raddr (m_raddr),
        .o_rdata (m_rdata)
    );

    // sequencer: state and registered results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_valid <= 1'b0;
            r_base  <= '0;
            r_free  <= '0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (int'(r_clr) == MAX_SLOTS - 1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_pos <= SW'(i_position_index);
                        r_tex <= i_texcoord_index;
                        if (!in_range) begin
                            r_valid <= 1'b1;
                            r_slot  <= '0;
                            r_clone <= 1'b0;
                            r_err   <= ERR_RANGE;
                        end else begin
                            r_state <= S_VCHK;
                        end
                    end
                end
                S_VCHK: begin
                    r_ve    <= rd;
                    r_s     <= rd.head;
                    r_steps <= '0;
                    if (!rd.used || rd.tex == r_tex) begin
                        r_valid <= 1'b1;
                        r_slot  <= POS_W'(r_pos);
                        r_clone <= 1'b0;
                        r_err   <= ERR_OK;
                        r_state <= S_IDLE;
                    end else if (rd.present) begin
                        r_state <= S_WALK;
                    end else begin
                        r_state <= S_ALLOC;
                    end
                end
                S_WALK: begin
                    if (rd.tex == r_tex) begin
                        r_valid <= 1'b1;
                        r_slot  <= POS_W'(r_s);
                        r_clone <= 1'b0;
                        r_err   <= ERR_OK;
                        r_state <= S_IDLE;
                    end else if (walk_more) begin
                        r_s     <= rd.nxt;
                        r_steps <= r_steps + 1'b1;
                    end else begin
                        r_state <= S_ALLOC;
                    end
                end
                S_ALLOC: begin
                    if (free_ok) begin
                        r_state <= S_FRESH;
                    end else begin
                        r_valid <= 1'b1;
                        r_slot  <= '0;
                        r_clone <= 1'b0;
                        r_err   <= ERR_FULL;
                        r_state <= S_IDLE;
                    end
                end
                S_FRESH: begin
                    r_fe    <= fresh_new;
                    r_state <= S_LINK;
                end
                S_LINK: begin
                    r_valid <= 1'b1;
                    r_slot  <= POS_W'(free_addr);
                    r_clone <= 1'b1;
                    r_err   <= ERR_OK;
                    r_free  <= r_free + 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (i_cfg_we) begin
                r_base <= i_cfg_wdata;
                r_free <= i_cfg_wdata;
            end
        end
    end

    assign busy         = (r_state != S_IDLE);
    assign o_valid      = r_valid;
    assign o_slot_index = r_slot;
    assign o_new_clone  = r_clone;
    assign o_error_code = r_err;

    // a new clone is only reported on success
    a_clone_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_new_clone |-> o_error_code == ERR_OK)
        else $error("new clone reported with an error");

    // any error reports slot zero
    a_err_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error_code != ERR_OK |-> o_slot_index == '0)
        else $error("error result with nonzero slot");

    // each allocated clone advances the free pointer by one
    a_free_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_new_clone && !$past(i_cfg_we)
            |-> r_free == CNT_W'($past(r_free) + 1'b1))
        else $error("free pointer did not advance on clone");

    // the slot table is never written while idle
    a_idle_nowr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !m_we)
        else $error("slot memory written while idle");

    // an item entering the walk always had a valid base entry read
    a_walk_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WALK && $past(r_state) == S_VCHK |-> r_ve.used && r_ve.present)
        else $error("chain walk started without a linked base vertex");

endmodule

>>> tb/uvs_slot_checker.sv
// ----------------------------------------------------------------------------
// uvs_slot_checker
// Watches the config, corner and slot channels of the UV seam vertex splitter,
// predicts the slot for every accepted corner and compares each result.
// ----------------------------------------------------------------------------
module uvs_slot_checker #(
    parameter int MAX_SLOTS = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [uvs_pkg::CNT_W-1:0]   i_cfg_wdata,
    input  logic                        i_start,
    input  logic                        i_busy,
    input  logic [uvs_pkg::POS_W-1:0]   i_position_index,
    input  logic [uvs_pkg::TEX_W-1:0]   i_texcoord_index,
    input  logic                        i_valid,
    input  logic [uvs_pkg::POS_W-1:0]   i_slot_index,
    input  logic                        i_new_clone,
    input  logic [uvs_pkg::ERR_W-1:0]   i_error_code,
    output int                          o_mismatches,
    output int                          o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import uvs_pkg::*;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [TEX_W-1:0] tex;
        logic [POS_W-1:0] slot;
        logic             new_clone;
        t_err             err;
    } t_slot_expect;

    // shadow of the slot table
    bit               slot_taken   [MAX_SLOTS];
    logic [TEX_W-1:0] slot_tex     [MAX_SLOTS];
    logic [POS_W-1:0] chain_head   [MAX_SLOTS];
    logic [POS_W-1:0] chain_next   [MAX_SLOTS];
    bit               chain_linked [MAX_SLOTS];
    logic [CNT_W-1:0] vertex_count;
    logic [CNT_W-1:0] free_slot;

    t_slot_expect expected_slots [$];
    int           mismatch_count;

    function automatic t_slot_expect map_corner(logic [POS_W-1:0] v, logic [TEX_W-1:0] t);
        t_slot_expect     r;
        logic [POS_W-1:0] s;
        logic [POS_W-1:0] fresh;
        bit               more;
        int               steps;
        r.pos       = v;
        r.tex       = t;
        r.slot      = '0;
        r.new_clone = 1'b0;
        r.err       = ERR_OK;
        if (v >= vertex_count || int'(v) >= MAX_SLOTS) begin
            r.err = ERR_RANGE;
            return r;
        end
        r.slot = v;
        if (!slot_taken[v]) begin
            slot_taken[v] = 1'b1;
            slot_tex[v]   = t;
            return r;
        end
        if (slot_tex[v] == t)
            return r;
        // walk the clone chain, bounded in case a reload made it circular
        more = chain_linked[v];
        s    = chain_head[v];
        for (steps = 0; more && steps < MAX_SLOTS; steps++) begin
            if (slot_tex[s] == t) begin
                r.slot = s;
                return r;
            end
            more = chain_linked[s];
            s    = chain_next[s];
        end
        if (free_slot >= MAX_SLOTS) begin
            r.slot = '0;
            r.err  = ERR_FULL;
            return r;
        end
        fresh                 = free_slot[POS_W-1:0];
        free_slot             = free_slot + 1'b1;
        slot_taken[fresh]     = 1'b1;
        slot_tex[fresh]       = t;
        chain_next[fresh]     = chain_head[v];
        chain_linked[fresh]   = chain_linked[v];
        chain_head[v]         = fresh;
        chain_linked[v]       = 1'b1;
        r.slot                = fresh;
        r.new_clone           = 1'b1;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_slot_expect want;
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_SLOTS; i++) begin
                slot_taken[i]   = 1'b0;
                chain_linked[i] = 1'b0;
                slot_tex[i]     = '0;
                chain_head[i]   = '0;
                chain_next[i]   = '0;
            end
            vertex_count = '0;
            free_slot    = '0;
            expected_slots.delete();
        end else begin
            // results first: an item taken at this edge cannot answer at it
            if (i_valid) begin
                if (expected_slots.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("unexpected slot result: slot=%0d clone=%0b err=%0d",
                                 i_slot_index, i_new_clone, i_error_code);
                    mismatch_count++;
                end else begin
                    want = expected_slots.pop_front();
                    if (i_slot_index !== want.slot || i_new_clone !== want.new_clone ||
                        i_error_code !== want.err) begin
                        if (mismatch_count < 10) begin
                            $display("slot mismatch pos=%0d tex=0x%04h: expected %0d/%0b/%0d",
                                     want.pos, want.tex, want.slot, want.new_clone,
                                     want.err);
                            $display("    got slot=%0d clone=%0b err=%0d",
                                     i_slot_index, i_new_clone, i_error_code);
                        end
                        mismatch_count++;
                    end
                end
            end
            if (i_cfg_we) begin
                vertex_count = i_cfg_wdata;
                free_slot    = i_cfg_wdata;
            end
            if (i_start && !i_busy)
                expected_slots.insert(expected_slots.size(),
                                      map_corner(i_position_index, i_texcoord_index));
        end
        o_mismatches  <= mismatch_count;
        o_outstanding <= expected_slots.size();
    end

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives face corners and base-count writes into the UV seam vertex splitter;
// a side checker predicts every slot and the verdict is printed here.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import uvs_pkg::*;

    localparam int SLOTS = 4096;

    logic               i_clk            = 1'b0;
    logic               i_rst_n          = 1'b0;
    logic               i_cfg_we         = 1'b0;
    logic [CNT_W-1:0]   i_cfg_wdata      = '0;
    logic               start            = 1'b0;
    logic               busy;
    logic [POS_W-1:0]   i_position_index = '0;
    logic [TEX_W-1:0]   i_texcoord_index = '0;
    logic               o_valid;
    logic [POS_W-1:0]   o_slot_index;
    logic               o_new_clone;
    logic [ERR_W-1:0]   o_error_code;

    int mismatches;
    int n_outstanding;

    // sender leaves random idle gaps between items only while this is set
    bit idle_on = 1'b1;

    // Slots ever handed out as clones. Such a slot may carry a live clone link
    // while its chain head was never written, so it is never used as a
    // position once a later base count brings it back into range.
    bit cloned_slot [SLOTS];

    // random phases: base count and item count of each
    int phase_base  [8] = '{40, 300, 2600, 4096, 4050, 3000, 500, 40};
    int phase_items [8] = '{130, 180, 180, 130, 130, 130, 100, 100};

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    uv_seam_vertex_split #(
        .MAX_SLOTS(SLOTS)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .start            (start),
        .busy             (busy),
        .i_position_index (i_position_index),
        .i_texcoord_index (i_texcoord_index),
        .o_valid          (o_valid),
        .o_slot_index     (o_slot_index),
        .o_new_clone      (o_new_clone),
        .o_error_code     (o_error_code)
    );

    uvs_slot_checker #(
        .MAX_SLOTS(SLOTS)
    ) chk (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_start          (start),
        .i_busy           (busy),
        .i_position_index (i_position_index),
        .i_texcoord_index (i_texcoord_index),
        .i_valid          (o_valid),
        .i_slot_index     (o_slot_index),
        .i_new_clone      (o_new_clone),
        .i_error_code     (o_error_code),
        .o_mismatches     (mismatches),
        .o_outstanding    (n_outstanding)
    );

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && o_new_clone)
            cloned_slot[o_slot_index] <= 1'b1;
    end

    // Hand one corner over; returns at the edge that takes it. A random
    // gap may follow so that idle cycles land on every step of the walk.
    task automatic offer_corner(input logic [POS_W-1:0] v, input logic [TEX_W-1:0] t);
        start            <= 1'b1;
        i_position_index <= v;
        i_texcoord_index <= t;
        do @(posedge i_clk); while (busy);
        if (idle_on && $urandom_range(0, 99) < 36) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // Stop sending and wait for every outstanding slot. The first edge is
    // always waited, since the checker's outstanding count is registered.
    task automatic settle();
        start <= 1'b0;
        do @(posedge i_clk); while (n_outstanding != 0 || busy);
    endtask

    // Base count writes happen only with the block drained and idle; each
    // one also reloads the free clone pointer.
    task automatic load_base(input int n);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= n[CNT_W-1:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        logic [POS_W-1:0] v;
        logic [TEX_W-1:0] t;
        logic [TEX_W-1:0] palette [6];
        int               base;
        int               win;
        int               tries;
        int               waited;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed ----
        // base count zero: every position is out of range
        load_base(0);
        offer_corner(12'd0, 16'h0000);
        offer_corner(12'd4095, 16'hFFFF);

        // small mesh: first use, direct hit, two clones, hit deep in chain
        load_base(16);
        offer_corner(12'd0, 16'hA5A5);
        offer_corner(12'd0, 16'hA5A5);
        offer_corner(12'd0, 16'h5A5A);
        offer_corner(12'd0, 16'hFFFF);
        offer_corner(12'd0, 16'h5A5A);
        offer_corner(12'd0, 16'hA5A5);
        offer_corner(12'd15, 16'h0000);
        offer_corner(12'd16, 16'h0001);   // index equal to base count
        offer_corner(12'd3, 16'hFFFF);

        // two free slots left: fill them, then table full; a position out
        // of range while the table is full must still report range
        load_base(4094);
        offer_corner(12'd4093, 16'h0007);
        offer_corner(12'd4093, 16'h0008);
        offer_corner(12'd4093, 16'h0009);
        offer_corner(12'd4093, 16'h000A);
        offer_corner(12'd4095, 16'h0001);

        // largest base count: no clone slot at all; older chains still hit
        load_base(4096);
        offer_corner(12'd2730, 16'h1234);
        offer_corner(12'd2730, 16'h4321);
        offer_corner(12'd0, 16'h0001);
        offer_corner(12'd0, 16'h5A5A);

        // ---- random phases ----
        // Corners come in bursts on a small window of vertices with a small
        // set of texcoords, so chains grow, get hit and overflow. Later
        // phases lower the base count again and reuse older clone slots.
        for (int ph = 0; ph < 8; ph++) begin
            base = phase_base[ph];
            load_base(base);
            idle_on = (ph != 2);
            for (int n = 0; n < phase_items[ph]; n++) begin
                if (n % 25 == 0) begin
                    win = $urandom_range(0, base - 1);
                    for (int k = 0; k < 6; k++)
                        palette[k] = TEX_W'($urandom);
                end
                if (base < SLOTS && $urandom_range(0, 99) < 5) begin
                    v = POS_W'($urandom_range(base, SLOTS - 1));
                end else begin
                    tries = 0;
                    do begin
                        v = POS_W'(win + int'($urandom_range(0, 23)));
                        if (v >= base)
                            v = POS_W'($urandom_range(0, base - 1));
                        tries++;
                    end while (cloned_slot[v] && tries < 8);
                    // low slots are never clones: base count is at least 16
                    if (cloned_slot[v])
                        v = '0;
                end
                if ($urandom_range(0, 9) == 0)
                    t = TEX_W'($urandom);
                else
                    t = palette[3'($urandom_range(0, 5))];
                offer_corner(v, t);
                // now and then hold off until the block has answered all
                if ($urandom_range(0, 99) < 2)
                    settle();
            end
        end

        // ---- drain and verdict ----
        start  <= 1'b0;
        waited = 0;
        do begin
            @(posedge i_clk);
            waited++;
        end while ((n_outstanding != 0 || busy) && waited < 50000);
        repeat (16) @(posedge i_clk);
        if (mismatches == 0 && n_outstanding == 0)
            $display("uv_seam_vertex_split test passed");
        else
            $display("uv_seam_vertex_split test failed");
        $finish;
    end

    // Hang guard: far beyond a run where every walk goes the full table.
    initial begin
        #200_000_000;
        $display("uv_seam_vertex_split test failed");
        $finish;
    end

endmodule

>>> sim.f
rtl/uvs_pkg.sv
rtl/uvs_slot_mem.sv
rtl/uv_seam_vertex_split.sv
tb/uvs_slot_checker.sv
tb/testbench.sv
